// ----- src/rbc_pkg.sv -----
package rbc_pkg;

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_WEIGHT  = 2'd1;
    localparam logic [1:0] OP_MODULUS = 2'd2;

    localparam logic [7:0] REG_ACTIVE_LIMBS = 8'd0;
    localparam logic [7:0] REG_OUT_COLUMNS  = 8'd1;

    localparam int MAX_RESULTS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_MOD,
        ST_DBL,
        ST_ADD,
        ST_ACC,
        ST_EMIT,
        ST_NEXT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic rd_start;
        logic load;
        logic mod_step;
        logic dbl_step;
        logic add_step;
        logic acc_step;
        logic emit;
        logic next_col;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic no_cols;
        logic skip_mul;
        logic bit_zero;
        logic col_last;
        logic item_last;
        logic out_free;
    } stat_t;

endpackage

// ----- src/rbc_ctrl.sv -----
module rbc_ctrl
    import rbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  data_accept,
    input  stat_t stat,
    output logic  idle,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (data_accept)
                begin
                    state_next = stat.no_cols ? ST_FIN : ST_RD;
                end
            end
            ST_RD:   state_next = ST_LOAD;
            ST_LOAD: state_next = stat.skip_mul ? ST_ACC : ST_MOD;
            ST_MOD:  state_next = stat.bit_zero ? ST_DBL : ST_MOD;
            ST_DBL:  state_next = ST_ADD;
            ST_ADD:  state_next = stat.bit_zero ? ST_ACC : ST_DBL;
            ST_ACC:  state_next = stat.item_last ? ST_EMIT : ST_NEXT;
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: state_next = stat.col_last ? ST_FIN : ST_RD;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        unique case (state_reg)
            ST_IDLE: idle = 1'b1;
            ST_RD:   cmd.rd_start = 1'b1;
            ST_LOAD: cmd.load = 1'b1;
            ST_MOD:  cmd.mod_step = 1'b1;
            ST_DBL:  cmd.dbl_step = 1'b1;
            ST_ADD:  cmd.add_step = 1'b1;
            ST_ACC:  cmd.acc_step = 1'b1;
            ST_EMIT: cmd.emit = stat.out_free;
            ST_NEXT: cmd.next_col = 1'b1;
            ST_FIN:  cmd.finish = 1'b1;
            default: idle = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_data_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && data_accept) |=> (state_reg != ST_IDLE))
        else $error("data item did not start processing");
    a_emit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> stat.item_last)
        else $error("result emitted for a non-final limb");
    a_add_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> (state_reg == ST_DBL || state_reg == ST_ACC))
        else $error("multiply sequence out of order");
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");
`endif

endmodule

// ----- src/rbc_datapath.sv -----
module rbc_datapath
    import rbc_pkg::*;
#(
    parameter int NUM_IN_LIMBS = 16,
    parameter int NUM_OUT_COLS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_accept,
    input  logic [1:0]  in_op,
    input  logic [3:0]  in_limb,
    input  logic [2:0]  in_col,
    input  logic [63:0] in_value,
    input  logic        in_last,
    input  logic [4:0]  active_limbs,
    input  logic [3:0]  out_columns,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_col,
    output logic [63:0] out_residue,
    output logic        out_last
);

    localparam int WDEPTH = NUM_IN_LIMBS * NUM_OUT_COLS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int CAW    = (NUM_OUT_COLS > 1) ? $clog2(NUM_OUT_COLS) : 1;
    localparam int NCAP   = (NUM_OUT_COLS < MAX_RESULTS) ? NUM_OUT_COLS : MAX_RESULTS;

    logic [63:0] weight_mem [WDEPTH];
    logic [63:0] acc_mem [NUM_OUT_COLS];
    logic [63:0] mod_mem [NUM_OUT_COLS];
    logic [NUM_OUT_COLS-1:0] acc_valid_reg;

    logic [3:0]  limb_reg;
    logic [63:0] x_reg;
    logic        last_reg;
    logic        lvalid_reg;
    logic [2:0]  col_reg;
    logic [63:0] w_reg, acc_rd_reg, m_reg;
    logic        acc_rd_valid_reg;
    logic [64:0] rem_reg;
    logic [63:0] r_reg;
    logic [5:0]  bit_reg;
    logic        skip_reg;
    logic [63:0] res_reg;
    logic        out_valid_reg;
    logic [2:0]  out_col_reg;
    logic [63:0] out_res_reg;
    logic        out_last_reg;

    logic [3:0]     ncols;
    logic [WAW-1:0] w_wr_addr, w_rd_addr;
    logic [64:0]    rem_sh, rem_sub, dbl, dbl_sub, addv, add_sub, acc_sum, acc_sub;
    logic [63:0]    acc_cur;

    always_comb
    begin
        ncols = out_columns;
        if (ncols > 4'(NCAP))
        begin
            ncols = 4'(NCAP);
        end
    end

    assign w_wr_addr = WAW'(32'(in_limb) * NUM_OUT_COLS + 32'(in_col));
    assign w_rd_addr = WAW'(32'(limb_reg) * NUM_OUT_COLS + 32'(col_reg));

    // table writes, accepted only while idle
    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == OP_WEIGHT && 32'(in_limb) < NUM_IN_LIMBS
            && 32'(in_col) < NUM_OUT_COLS)
        begin
            weight_mem[w_wr_addr] <= in_value;
        end
        if (in_accept && in_op == OP_MODULUS && 32'(in_col) < NUM_OUT_COLS)
        begin
            mod_mem[CAW'(in_col)] <= in_value;
        end
        if (cmd.rd_start)
        begin
            w_reg      <= weight_mem[w_rd_addr];
            acc_rd_reg <= acc_mem[CAW'(col_reg)];
            m_reg      <= mod_mem[CAW'(col_reg)];
        end
        if (cmd.acc_step)
        begin
            acc_mem[CAW'(col_reg)] <= acc_sub[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg    <= '0;
            acc_rd_valid_reg <= 1'b0;
            col_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.rd_start)
            begin
                acc_rd_valid_reg <= acc_valid_reg[CAW'(col_reg)];
            end
            if (cmd.acc_step)
            begin
                acc_valid_reg[CAW'(col_reg)] <= 1'b1;
            end
            if (cmd.finish && last_reg)
            begin
                acc_valid_reg <= '0;
            end
            if (in_accept && in_op == OP_DATA)
            begin
                col_reg <= '0;
            end
            else if (cmd.next_col)
            begin
                col_reg <= col_reg + 3'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // remainder, doubling and add steps of the shared modular unit
    assign rem_sh  = {rem_reg[63:0], x_reg[bit_reg]};
    assign rem_sub = (rem_sh >= {1'b0, m_reg}) ? rem_sh - {1'b0, m_reg} : rem_sh;
    assign dbl     = {r_reg, 1'b0};
    assign dbl_sub = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
    assign addv    = {1'b0, r_reg} + rem_reg;
    assign add_sub = (addv >= {1'b0, m_reg}) ? addv - {1'b0, m_reg} : addv;
    assign acc_cur = acc_rd_valid_reg ? acc_rd_reg : 64'd0;
    assign acc_sum = {1'b0, acc_cur} + {1'b0, (skip_reg ? 64'd0 : r_reg)};
    assign acc_sub = (acc_sum >= {1'b0, m_reg}) ? acc_sum - {1'b0, m_reg} : acc_sum;

    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == OP_DATA)
        begin
            limb_reg   <= in_limb;
            x_reg      <= in_value;
            last_reg   <= in_last;
            lvalid_reg <= ({1'b0, in_limb} < active_limbs) && (32'(in_limb) < NUM_IN_LIMBS);
        end
        if (cmd.load)
        begin
            rem_reg  <= '0;
            r_reg    <= '0;
            bit_reg  <= 6'd63;
            skip_reg <= !lvalid_reg || (m_reg == 64'd0);
        end
        if (cmd.mod_step)
        begin
            rem_reg <= rem_sub;
            bit_reg <= bit_reg - 6'd1;
        end
        if (cmd.dbl_step)
        begin
            r_reg <= dbl_sub[63:0];
        end
        if (cmd.add_step)
        begin
            if (w_reg[bit_reg])
            begin
                r_reg <= add_sub[63:0];
            end
            bit_reg <= bit_reg - 6'd1;
        end
        if (cmd.acc_step)
        begin
            res_reg <= acc_sub[63:0];
        end
        if (cmd.emit)
        begin
            out_col_reg  <= col_reg;
            out_res_reg  <= res_reg;
            out_last_reg <= ({1'b0, col_reg} + 4'd1 == ncols);
        end
    end

    assign stat.no_cols   = (ncols == 4'd0);
    assign stat.skip_mul  = !lvalid_reg || (m_reg == 64'd0);
    assign stat.bit_zero  = (bit_reg == 6'd0);
    assign stat.col_last  = ({1'b0, col_reg} + 4'd1 == ncols);
    assign stat.item_last = last_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_col     = out_col_reg;
    assign out_residue = out_res_reg;
    assign out_last    = out_last_reg;

endmodule

// ----- src/rns_basis_conversion_mac.sv -----
// channel   | direction | contents
// s_axis    | in        | op in tuser, last_limb in tlast, limb/column/value in tdata
// m_axis    | out       | out_last in tlast, out_column/out_residue in tdata
// cfg       | in        | register index and write data, always ready
//
// a weight or modulus write is taken while idle and the input stays ready
// a data item holds the input off while it runs each active column (read, load,
// 64 remainder steps, 128 multiply steps, accumulate, next column); a skipped product
// goes from load to accumulate, the last limb adds an emit per column, then finish
// reset idles the controller, clears accumulator valid bits and output, presets config registers
// a stalled output holds the column loop in the emit state
module rns_basis_conversion_mac
    import rbc_pkg::*;
#(
    parameter int NUM_IN_LIMBS = 16,
    parameter int NUM_OUT_COLS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // limb_index[3:0], column_index[6:4], item_value[70:7], zero
    input  logic [1:0]  s_axis_tuser,  // op
    input  logic        s_axis_tlast,  // last_limb
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // out_column[2:0], out_residue[66:3], zero
    output logic        m_axis_tlast,  // out_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [4:0]  active_limbs_reg;
    logic [3:0]  out_columns_reg;
    logic        idle;
    logic        in_accept;
    cmd_t        cmd;
    stat_t       stat;
    logic [2:0]  out_col;
    logic [63:0] out_residue;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_limbs_reg <= 5'd16;
            out_columns_reg  <= 4'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ACTIVE_LIMBS: active_limbs_reg <= cfg_data[4:0];
                REG_OUT_COLUMNS:  out_columns_reg  <= cfg_data[3:0];
                default:          active_limbs_reg <= active_limbs_reg;
            endcase
        end
    end

    rbc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_accept (in_accept && s_axis_tuser == OP_DATA),
        .stat        (stat),
        .idle        (idle),
        .cmd         (cmd)
    );

    rbc_datapath #(
        .NUM_IN_LIMBS (NUM_IN_LIMBS),
        .NUM_OUT_COLS (NUM_OUT_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .in_op        (s_axis_tuser),
        .in_limb      (s_axis_tdata[3:0]),
        .in_col       (s_axis_tdata[6:4]),
        .in_value     (s_axis_tdata[70:7]),
        .in_last      (s_axis_tlast),
        .active_limbs (active_limbs_reg),
        .out_columns  (out_columns_reg),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_col      (out_col),
        .out_residue  (out_residue),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_residue, out_col};

endmodule

// ----- verif/rns_basis_conversion_mac_test.sv -----
`timescale 1ns / 1ps

// self-checking bench for the rns basis conversion multiply-accumulate block
// a behavioral model predicts every converted residue; each output
// transaction is compared against the oldest prediction
module rns_basis_conversion_mac_test;
    import rbc_pkg::*;

    localparam int LIMBS = 16;
    localparam int COLS = 8;
    // unused op code, ignored by the block
    localparam logic [1:0] OP_NONE = 2'd3;
    // a data item can occupy the block across all 8 columns
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct packed {
        logic [2:0]  column;
        logic [63:0] residue;
        logic        last;
    } conv_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // limb_index[3:0], column_index[6:4], item_value[70:7], zero
    logic [1:0]  s_axis_tuser;   // op
    logic        s_axis_tlast;   // last_limb
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // out_column[2:0], out_residue[66:3], zero
    logic        m_axis_tlast;   // out_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;

    // model state
    logic [63:0]  weights [LIMBS*COLS];
    logic [63:0]  moduli [COLS];
    logic [63:0]  accums [COLS];
    logic [4:0]   limb_count;
    logic [3:0]   col_count;
    conv_result_t pending_results [$];

    int  failures;
    int  idle_cycles;
    bit  long_stall;
    bit  stall_enable;

    rns_basis_conversion_mac dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // exact (a * b) mod m, zero for a zero modulus
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        if (m == 64'd0)
            return 64'd0;
        prod = 128'(a) * 128'(b);
        return 64'(prod % 128'(m));
    endfunction

    // apply one input transaction to the model, queue any results
    task automatic predict_item(logic [1:0] op, logic [3:0] limb, logic [2:0] col,
                                logic [63:0] value, logic last);
        int n;
        logic use_limb;
        logic [63:0] prod;
        logic [64:0] sum;
        conv_result_t r;
        n = (col_count > COLS) ? COLS : int'(col_count);
        if (op == OP_WEIGHT)
            weights[limb*COLS + col] = value;
        else if (op == OP_MODULUS)
            moduli[col] = value;
        else if (op == OP_DATA)
        begin
            use_limb = (limb < limb_count);
            for (int p = 0; p < n; p++)
            begin
                prod = use_limb ? mulmod(value, weights[limb*COLS + p], moduli[p]) : 64'd0;
                sum = 65'(accums[p]) + 65'(prod);
                // one conditional subtract brings the 65 bit sum back
                if (sum >= 65'(moduli[p]))
                    sum = sum - 65'(moduli[p]);
                accums[p] = sum[63:0];
            end
            if (last)
            begin
                for (int p = 0; p < n; p++)
                begin
                    r.column = 3'(p);
                    r.residue = accums[p];
                    r.last = (p == n - 1);
                    pending_results.push_back(r);
                end
                for (int p = 0; p < COLS; p++)
                    accums[p] = 64'd0;
            end
        end
    endtask

    // one input transaction; tvalid stays up into the next one unless a gap
    // ends the burst
    task automatic send_item(logic [1:0] op, logic [3:0] limb, logic [2:0] col,
                             logic [63:0] value, logic last);
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {1'b0, value, col, limb};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_item(op, limb, col, value, last);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(logic [7:0] index, logic [7:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_ACTIVE_LIMBS)
            limb_count = value[4:0];
        else if (index == REG_OUT_COLUMNS)
            col_count = value[3:0];
    endtask

    // end the input burst and let the block drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // fill every weight and modulus that the active limbs and columns read
    task automatic load_tables(bit extreme, int limbs, int cols);
        for (int c = 0; c < cols; c++)
            send_item(OP_MODULUS, 4'd0, 3'(c),
                      extreme ? (c[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd1) : rand64() | 64'd1, 1'b0);
        for (int l = 0; l < limbs; l++)
            for (int c = 0; c < cols; c++)
                send_item(OP_WEIGHT, 4'(l), 3'(c),
                          extreme ? 64'hFFFF_FFFF_FFFF_FFFF : rand64(), 1'b0);
    endtask

    task automatic test_directed();
        write_reg(REG_ACTIVE_LIMBS, 8'd2);
        write_reg(REG_OUT_COLUMNS, 8'd3);
        load_tables(1'b1, 2, 3);
        // all-ones and near all-ones residues against all-ones weights, moduli of one and all-ones
        send_item(OP_DATA, 4'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_DATA, 4'd1, 3'd7, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        // limb above the count reads as zero
        send_item(OP_DATA, 4'd3, 3'd0, rand64(), 1'b1);
        // unused op code is ignored
        send_item(OP_NONE, 4'd5, 3'd2, rand64(), 1'b1);
        // zero modulus leaves the accumulator alone
        send_item(OP_MODULUS, 4'd0, 3'd2, 64'd0, 1'b0);
        send_item(OP_DATA, 4'd0, 3'd0, rand64(), 1'b1);
        // tiny set, limbs above the count read as zero
        write_reg(REG_ACTIVE_LIMBS, 8'd1);
        write_reg(REG_OUT_COLUMNS, 8'd1);
        send_item(OP_DATA, 4'd0, 3'd0, 64'h8000_0000_0000_0001, 1'b0);
        send_item(OP_DATA, 4'd1, 3'd0, rand64(), 1'b1);
        // no active columns: nothing comes out
        write_reg(REG_OUT_COLUMNS, 8'd0);
        send_item(OP_DATA, 4'd0, 3'd0, rand64(), 1'b1);
        // column count saturates, 5 bit limb count upper bit
        write_reg(REG_OUT_COLUMNS, 8'd15);
        write_reg(REG_ACTIVE_LIMBS, 8'd31);
        for (int c = 3; c < COLS; c++)
            send_item(OP_MODULUS, 4'd0, 3'(c), rand64() | 64'd1, 1'b0);
        for (int c = 3; c < COLS; c++)
            send_item(OP_WEIGHT, 4'd0, 3'(c), rand64(), 1'b0);
        send_item(OP_DATA, 4'd0, 3'd0, rand64(), 1'b1);
    endtask

    task automatic test_random(int count, int cols, int limbs);
        int limb;
        int last_limb;
        write_reg(REG_OUT_COLUMNS, 8'(cols));
        write_reg(REG_ACTIVE_LIMBS, 8'(limbs));
        load_tables(1'b0, limbs, cols);
        limb = 0;
        last_limb = $urandom_range(0, 3);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(1, 3)), 4'($urandom()), 3'($urandom()),
                          rand64() | 64'd1, 1'($urandom()));
            else
            begin
                send_item(OP_DATA, 4'(limb), 3'($urandom()), rand64(), limb == last_limb);
                if (limb == last_limb)
                begin
                    limb = 0;
                    last_limb = $urandom_range(0, 3);
                end
                else
                    limb++;
            end
        end
        // close the open coefficient
        send_item(OP_DATA, 4'd15, 3'd0, rand64(), 1'b1);
    endtask

    // long receiver hold-off while items keep coming
    task automatic test_backpressure();
        write_reg(REG_OUT_COLUMNS, 8'd2);
        long_stall = 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(OP_DATA, 4'd0, 3'd0, rand64(), 1'b1);
    endtask

    // receiver: random stall pattern, plus one long stall counted here
    always @(posedge clk)
    begin
        if (long_stall)
        begin
            m_axis_tready <= 1'b0;
            repeat (3000) @(posedge clk);
            long_stall = 1'b0;
        end
        else
            m_axis_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        conv_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t: unexpected result column %0d residue %h", $time,
                         m_axis_tdata[2:0], m_axis_tdata[66:3]);
                failures++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.column !== m_axis_tdata[2:0] || exp_r.residue !== m_axis_tdata[66:3]
                    || exp_r.last !== m_axis_tlast)
                begin
                    $display("%t: expected col %0d res %h last %b, actual col %0d res %h last %b",
                             $time, exp_r.column, exp_r.residue, exp_r.last,
                             m_axis_tdata[2:0], m_axis_tdata[66:3], m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failures = 0;
        idle_cycles = 0;
        long_stall = 1'b0;
        stall_enable = 1'b0;
        limb_count = 5'd16;
        col_count = 4'd8;
        for (int p = 0; p < COLS; p++)
            accums[p] = 64'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_enable = 1'b1;
        test_random(30, 3, 4);
        test_random(25, 1, 8);
        test_random(15, 8, 3);
        test_backpressure();
        wait_idle();
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- rns_basis_conversion_mac.f -----
src/rbc_pkg.sv
src/rbc_ctrl.sv
src/rbc_datapath.sv
src/rns_basis_conversion_mac.sv
verif/rns_basis_conversion_mac_test.sv
